[rtl/lstd_pkg.sv]
// Shared types and constants for the schedule table dispatcher.
package lstd_pkg;

   localparam int OFFSET_W    = 16;
   localparam int FLAGS_W     = 4;
   localparam int TICK_W      = 32;
   localparam int SLOT_W      = 5;
   localparam int TASK_OUT_W  = 8;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   localparam logic [1:0] REG_TABLE_SIZE   = 2'd0;
   localparam logic [1:0] REG_MACRO_PERIOD = 2'd1;
   localparam logic [1:0] REG_USE_EVENT    = 2'd2;
   localparam logic [1:0] REG_TERM_ENABLE  = 2'd3;

   localparam int FLAG_ACTIVATE = 0;
   localparam int FLAG_SWAP     = 1;
   localparam int FLAG_LET      = 2;
   localparam int FLAG_TERM     = 3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_LOOK,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_ARMED,
      PH_RUN
   } phase_type;

endpackage

[rtl/let_schedule_table_dispatcher_top.sv]
// Schedule table dispatcher: table memory, dispatch sequencer and control registers.
// Write-entry, start and unused transactions do not hold the input; a non-matching tick
// holds it while in CHECK. A match in CHECK leads, for each entry, through LOOK (next entry
// offset compare) to EMIT, which registers the result; an entry just before the wrap skips
// LOOK. EMIT waits while rsp_stall holds the output. The input stalls until the run ends.
// Synchronous reset clears control state and registers; the table is not cleared.
module let_schedule_table_dispatcher_top #(
   parameter int TABLE_DEPTH = 32,
   parameter int TASK_BITS   = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_opcode,
   input  logic [lstd_pkg::TICK_W-1:0]        req_tick_value,
   input  logic [lstd_pkg::SLOT_W-1:0]        req_entry_slot,
   input  logic [lstd_pkg::OFFSET_W-1:0]      req_entry_offset,
   input  logic [lstd_pkg::FLAGS_W-1:0]       req_entry_flags,
   input  logic [lstd_pkg::TASK_OUT_W-1:0]    req_entry_task,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [lstd_pkg::TASK_OUT_W-1:0]    rsp_task_number,
   output logic [lstd_pkg::SLOT_W-1:0]        rsp_slot_number,
   output logic                               rsp_do_activate,
   output logic                               rsp_do_swap,
   output logic                               rsp_do_set_event,
   output logic                               rsp_do_term_event,
   output logic                               rsp_last_of_run,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lstd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [lstd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [lstd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int SZ_W  = $clog2(TABLE_DEPTH + 1);
   localparam int MEM_W = lstd_pkg::OFFSET_W + lstd_pkg::FLAGS_W + TASK_BITS;

   // configuration registers
   logic [5:0]  cfg_table_size_ff;
   logic [31:0] cfg_macro_period_ff;
   logic        cfg_use_event_ff;
   logic        cfg_term_enable_ff;
   logic        csr_write;

   // control and datapath registers
   lstd_pkg::state_type state_ff, state_in;
   lstd_pkg::phase_type phase_ff, phase_in;
   logic [IDX_W-1:0]                  idx_ff, idx_in;
   logic [IDX_W-1:0]                  ptr_ff, ptr_in;
   logic [lstd_pkg::TICK_W-1:0]       base_ff, base_in;
   logic [lstd_pkg::TICK_W-1:0]       tick_ff, tick_in;
   logic [lstd_pkg::OFFSET_W-1:0]     run_off_ff, run_off_in;
   logic [lstd_pkg::FLAGS_W-1:0]      cur_flags_ff, cur_flags_in;
   logic [TASK_BITS-1:0]              cur_task_ff, cur_task_in;
   logic [IDX_W-1:0]                  cur_slot_ff, cur_slot_in;
   logic                              last_ff, last_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [lstd_pkg::TASK_OUT_W-1:0]   rsp_task_ff, rsp_task_in;
   logic [lstd_pkg::SLOT_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic                              rsp_act_ff, rsp_act_in;
   logic                              rsp_swp_ff, rsp_swp_in;
   logic                              rsp_sev_ff, rsp_sev_in;
   logic                              rsp_term_ff, rsp_term_in;
   logic                              rsp_last_ff, rsp_last_in;

   // table memory
   logic [MEM_W-1:0] mem [TABLE_DEPTH];
   logic [MEM_W-1:0] q_ff;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [MEM_W-1:0] wr_data;
   logic [31:0]      slot_ext;
   logic [31:0]      task_in_ext;

   logic [lstd_pkg::OFFSET_W-1:0] q_offset;
   logic [lstd_pkg::FLAGS_W-1:0]  q_flags;
   logic [TASK_BITS-1:0]          q_task;

   logic [31:0]      size_ext;
   logic [31:0]      size_sel;
   logic [SZ_W-1:0]  eff_size;
   logic [IDX_W-1:0] norm_idx;
   logic [SZ_W-1:0]  inc;
   logic [IDX_W-1:0] nxt;
   logic             req_accept;
   logic             out_free;
   logic             match;
   logic [31:0]      cur_task_ext;
   logic [31:0]      cur_slot_ext;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_table_size_ff   <= 6'd1;
         cfg_macro_period_ff <= 32'd1;
         cfg_use_event_ff    <= 1'b0;
         cfg_term_enable_ff  <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            lstd_pkg::REG_TABLE_SIZE:   cfg_table_size_ff   <= csr_pwdata[5:0];
            lstd_pkg::REG_MACRO_PERIOD: cfg_macro_period_ff <= csr_pwdata;
            lstd_pkg::REG_USE_EVENT:    cfg_use_event_ff    <= csr_pwdata[0];
            lstd_pkg::REG_TERM_ENABLE:  cfg_term_enable_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         lstd_pkg::REG_TABLE_SIZE:   csr_prdata = 32'(cfg_table_size_ff);
         lstd_pkg::REG_MACRO_PERIOD: csr_prdata = cfg_macro_period_ff;
         lstd_pkg::REG_USE_EVENT:    csr_prdata = 32'(cfg_use_event_ff);
         lstd_pkg::REG_TERM_ENABLE:  csr_prdata = 32'(cfg_term_enable_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // handshake
   assign req_stall  = (state_ff != lstd_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // effective size and index arithmetic
   assign size_ext = 32'(cfg_table_size_ff);
   always_comb begin
      if (size_ext == 32'd0) begin
         size_sel = 32'd1;
      end else if (size_ext > 32'(TABLE_DEPTH)) begin
         size_sel = 32'(TABLE_DEPTH);
      end else begin
         size_sel = size_ext;
      end
   end
   assign eff_size = size_sel[SZ_W-1:0];
   assign norm_idx = (SZ_W'(idx_ff) >= eff_size) ? '0 : idx_ff;
   assign inc      = SZ_W'(ptr_ff) + SZ_W'(1);
   assign nxt      = (inc >= eff_size) ? '0 : inc[IDX_W-1:0];

   // table write and read
   assign slot_ext    = 32'(req_entry_slot);
   assign task_in_ext = 32'(req_entry_task);
   assign wr_en   = req_accept && (req_opcode == lstd_pkg::OP_WRITE)
                    && (slot_ext < 32'(TABLE_DEPTH));
   assign wr_addr = slot_ext[IDX_W-1:0];
   assign wr_data = {req_entry_offset, req_entry_flags, task_in_ext[TASK_BITS-1:0]};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      q_ff <= mem[ptr_in];
   end

   assign q_task   = q_ff[TASK_BITS-1:0];
   assign q_flags  = q_ff[TASK_BITS+lstd_pkg::FLAGS_W-1:TASK_BITS];
   assign q_offset = q_ff[MEM_W-1:TASK_BITS+lstd_pkg::FLAGS_W];
   assign match    = ((base_ff + 32'(q_offset)) == tick_ff);

   assign cur_task_ext = 32'(cur_task_ff);
   assign cur_slot_ext = 32'(cur_slot_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lstd_pkg::ST_IDLE: begin
            if (req_accept && (req_opcode == lstd_pkg::OP_TICK)
                && (phase_ff != lstd_pkg::PH_IDLE)) begin
               state_in = lstd_pkg::ST_CHECK;
            end
         end
         lstd_pkg::ST_CHECK: begin
            if (!match) begin
               state_in = lstd_pkg::ST_IDLE;
            end else if (nxt == '0) begin
               state_in = lstd_pkg::ST_EMIT;
            end else begin
               state_in = lstd_pkg::ST_LOOK;
            end
         end
         lstd_pkg::ST_LOOK: begin
            state_in = lstd_pkg::ST_EMIT;
         end
         lstd_pkg::ST_EMIT: begin
            if (out_free) begin
               if (last_ff) begin
                  state_in = lstd_pkg::ST_IDLE;
               end else if (nxt == '0) begin
                  state_in = lstd_pkg::ST_EMIT;
               end else begin
                  state_in = lstd_pkg::ST_LOOK;
               end
            end
         end
         default: state_in = lstd_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      idx_in       = idx_ff;
      ptr_in       = ptr_ff;
      base_in      = base_ff;
      tick_in      = tick_ff;
      phase_in     = phase_ff;
      run_off_in   = run_off_ff;
      cur_flags_in = cur_flags_ff;
      cur_task_in  = cur_task_ff;
      cur_slot_in  = cur_slot_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_task_in  = rsp_task_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_act_in   = rsp_act_ff;
      rsp_swp_in   = rsp_swp_ff;
      rsp_sev_in   = rsp_sev_ff;
      rsp_term_in  = rsp_term_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         lstd_pkg::ST_IDLE: begin
            ptr_in = norm_idx;
            if (req_accept) begin
               unique case (req_opcode)
                  lstd_pkg::OP_START: begin
                     idx_in   = '0;
                     phase_in = lstd_pkg::PH_ARMED;
                  end
                  lstd_pkg::OP_TICK: begin
                     if (phase_ff != lstd_pkg::PH_IDLE) begin
                        idx_in  = norm_idx;
                        tick_in = req_tick_value;
                        if (phase_ff == lstd_pkg::PH_ARMED) begin
                           base_in  = req_tick_value;
                           phase_in = lstd_pkg::PH_RUN;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         lstd_pkg::ST_CHECK: begin
            if (match) begin
               cur_flags_in = q_flags;
               cur_task_in  = q_task;
               cur_slot_in  = ptr_ff;
               run_off_in   = q_offset;
               ptr_in       = nxt;
               last_in      = (nxt == '0);
            end
         end
         lstd_pkg::ST_LOOK: begin
            last_in = (q_offset != run_off_ff);
         end
         lstd_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_task_in  = cur_task_ext[lstd_pkg::TASK_OUT_W-1:0];
               rsp_slot_in  = cur_slot_ext[lstd_pkg::SLOT_W-1:0];
               rsp_act_in   = cur_flags_ff[lstd_pkg::FLAG_ACTIVATE]
                              || (cur_flags_ff[lstd_pkg::FLAG_LET] && !cfg_use_event_ff);
               rsp_swp_in   = !cur_flags_ff[lstd_pkg::FLAG_ACTIVATE]
                              && cur_flags_ff[lstd_pkg::FLAG_SWAP];
               rsp_sev_in   = !cur_flags_ff[lstd_pkg::FLAG_ACTIVATE]
                              && cur_flags_ff[lstd_pkg::FLAG_LET] && cfg_use_event_ff;
               rsp_term_in  = !cur_flags_ff[lstd_pkg::FLAG_ACTIVATE]
                              && cur_flags_ff[lstd_pkg::FLAG_TERM] && cfg_term_enable_ff;
               rsp_last_in  = last_ff;
               if (last_ff) begin
                  idx_in = ptr_ff;
                  if (ptr_ff == '0) begin
                     base_in = base_ff + cfg_macro_period_ff;
                  end
               end else begin
                  cur_flags_in = q_flags;
                  cur_task_in  = q_task;
                  cur_slot_in  = ptr_ff;
                  ptr_in       = nxt;
                  last_in      = (nxt == '0);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lstd_pkg::ST_IDLE;
         phase_ff     <= lstd_pkg::PH_IDLE;
         idx_ff       <= '0;
         ptr_ff       <= '0;
         base_ff      <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         ptr_ff       <= ptr_in;
         base_ff      <= base_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tick_ff      <= tick_in;
      run_off_ff   <= run_off_in;
      cur_flags_ff <= cur_flags_in;
      cur_task_ff  <= cur_task_in;
      cur_slot_ff  <= cur_slot_in;
      rsp_task_ff  <= rsp_task_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_act_ff   <= rsp_act_in;
      rsp_swp_ff   <= rsp_swp_in;
      rsp_sev_ff   <= rsp_sev_in;
      rsp_term_ff  <= rsp_term_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_task_number   = rsp_task_ff;
   assign rsp_slot_number   = rsp_slot_ff;
   assign rsp_do_activate   = rsp_act_ff;
   assign rsp_do_swap       = rsp_swp_ff;
   assign rsp_do_set_event  = rsp_sev_ff;
   assign rsp_do_term_event = rsp_term_ff;
   assign rsp_last_of_run   = rsp_last_ff;

endmodule

[rtl/lstd_checker.sv]
// Port-level assertions for the schedule table dispatcher, bound to the top level.
module lstd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic [1:0]                      req_opcode,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [lstd_pkg::TASK_OUT_W-1:0] rsp_task_number,
   input logic [lstd_pkg::SLOT_W-1:0]     rsp_slot_number,
   input logic                            rsp_last_of_run
);

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_task_number)
                                       && $stable(rsp_slot_number)
                                       && $stable(rsp_last_of_run));
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("stalled rsp transaction changed");

   property p_non_tick_one_cycle;
      @(posedge clock) disable iff (reset)
         (req_valid && !req_stall && (req_opcode != lstd_pkg::OP_TICK)) |=> !req_stall;
   endproperty
   a_non_tick_one_cycle: assert property (p_non_tick_one_cycle)
      else $error("non-tick transaction held the input");

   property p_no_early_result;
      @(posedge clock) disable iff (reset)
         (req_valid && !req_stall) |=> !$rose(rsp_valid);
   endproperty
   a_no_early_result: assert property (p_no_early_result)
      else $error("result appeared one cycle after a transaction");

   property p_reset_clears;
      @(posedge clock) reset |=> (!rsp_valid && !req_stall);
   endproperty
   a_reset_clears: assert property (p_reset_clears) else $error("reset left control active");

endmodule

bind let_schedule_table_dispatcher_top lstd_checker u_lstd_checker (.*);
